// ----- src/clip_frame_playback_sampler_top_assert.svh -----
// Assertion macros for the clip frame playback sampler.
// Expects clk and rst_n in the scope of the module that includes it.
`ifndef CLIP_FRAME_PLAYBACK_SAMPLER_TOP_ASSERT_SVH
`define CLIP_FRAME_PLAYBACK_SAMPLER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CFPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CFPS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFPS_ASSERT(lbl, prop, msg)
`define CFPS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- src/cfps_pkg.sv -----
// Types and constants for the clip frame playback sampler.
// No dependencies.
package cfps_pkg;

  localparam int unsigned MAX_CLIPS          = 16;
  localparam int unsigned MAX_FRAMES         = 1024;
  localparam int unsigned FLASH_MIN_DURATION = 6;

  localparam logic [4:0]  CLIP_COUNT_RST  = 5'd4;
  localparam logic [10:0] FRAMES_RST      = 11'd32;
  localparam logic [7:0]  SAMPLE_RATE_RST = 8'd30;
  localparam logic [15:0] LOOP_MASK_RST   = 16'd3;

  // divider pipeline: 32 remainder bits and 16 quotient bits over 8 stages
  localparam int unsigned DIV_STAGES = 8;
  localparam int unsigned MOD_STEPS  = 4;
  localparam int unsigned FQ_STEPS   = 2;

  typedef enum logic [1:0] {
    REG_CLIP_COUNT  = 2'd0,
    REG_FRAMES      = 2'd1,
    REG_SAMPLE_RATE = 2'd2,
    REG_LOOP_MASK   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        [7:0]  clip_state;
    logic signed [31:0] now_time;
    logic signed [31:0] state_start_time;
    logic signed [15:0] play_rate;
    logic        [31:0] phase_seed;
    logic signed [31:0] flash_revision;
    logic signed [31:0] flash_start_time;
    logic signed [31:0] flash_duration;
    logic signed [15:0] flash_peak;
  } in_t;

  typedef struct packed {
    logic        result_valid;
    logic [3:0]  clip_index;
    logic        is_looping;
    logic [21:0] frame_pos;
    logic [21:0] prior_frame_pos;
    logic [14:0] flash_level;
  } out_t;

endpackage

// ----- src/clip_frame_playback_sampler_top.sv -----
// Clip frame playback sampler: config registers and a 12-register pipeline.
// Depends on cfps_pkg and clip_frame_playback_sampler_top_assert.svh.
//
// Usage:
//   in_valid/in_ready/in_data carry one request (in_t) per transfer.
//   out_valid/out_ready/out_data carry one result (out_t) per request, in order.
//   cfg_valid/cfg_ready/cfg_index/cfg_wdata write one register per transfer;
//   cfg_ready is always high. Write only while no request is in flight.
// Path: each request is registered in s1_r, s2_r, dv_r[0] to dv_r[8] and out_r, in that order.
// Throughput: one request per cycle unless stalled. The two 32-bit
//   remainders and the flash division run as an 8-stage pipelined divider
//   (4 and 2 bits a stage); each stage takes a new item every unstalled cycle.
// Stall: the whole pipeline holds while out_valid is high and out_ready low;
//   in_ready then falls, and nothing is lost or repeated.
// Reset: rst_n (synchronous, active low) empties the pipeline and loads the
//   default register values (4 clips, 32 frames, 30 fps, clips 0 and 1 loop).
// Clip indices at or beyond the clip count give an all-zero result.
module clip_frame_playback_sampler_top
  import cfps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_reg_t    cfg_index,
  input  logic [15:0] cfg_wdata
);

`include "clip_frame_playback_sampler_top_assert.svh"

  typedef struct packed {
    logic        vld;
    logic        ok;
    logic        loop;
    logic [3:0]  clip;
    logic [31:0] elapsed;
    logic [14:0] urate;
    logic [31:0] seed;
    logic [30:0] fdiff;
    logic [30:0] fdur;
    logic [14:0] peak;
  } s1_t;

  typedef struct packed {
    logic        vld;
    logic        ok;
    logic        loop;
    logic [3:0]  clip;
    logic [39:0] prod;
    logic [14:0] urate;
    logic [31:0] seed;
    logic [45:0] fnum;
    logic [30:0] fdur;
  } s2_t;

  typedef struct packed {
    logic        vld;
    logic        ok;
    logic        loop;
    logic [3:0]  clip;
    logic [38:0] local_pos;
    logic [31:0] seed;
    logic [10:0] srem;
    logic [10:0] lrem;
    logic [45:0] fnum;
    logic [30:0] fdur;
    logic [31:0] frem;
    logic [15:0] fq;
  } dv_t;

  logic [4:0]  clip_count_r;
  logic [10:0] frames_r;
  logic [7:0]  sample_rate_r;
  logic [15:0] loop_mask_r;

  logic [4:0]  count_eff;
  logic [10:0] frames_eff;
  logic        en;

  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  dv_t  dv_r [DIV_STAGES+1];
  dv_t  dv_nxt [DIV_STAGES+1];
  logic out_valid_r;
  out_t out_r, out_nxt;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_count_r  <= CLIP_COUNT_RST;
      frames_r      <= FRAMES_RST;
      sample_rate_r <= SAMPLE_RATE_RST;
      loop_mask_r   <= LOOP_MASK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CLIP_COUNT:  clip_count_r  <= cfg_wdata[4:0];
        REG_FRAMES:      frames_r      <= cfg_wdata[10:0];
        REG_SAMPLE_RATE: sample_rate_r <= cfg_wdata[7:0];
        REG_LOOP_MASK:   loop_mask_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    count_eff = (clip_count_r > 5'(MAX_CLIPS)) ? 5'(MAX_CLIPS) : clip_count_r;
    if (frames_r == 11'd0)
      frames_eff = 11'd1;
    else if (frames_r > 11'(MAX_FRAMES))
      frames_eff = 11'(MAX_FRAMES);
    else
      frames_eff = frames_r;
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  function automatic logic [10:0] mod_step(input logic [10:0] rem, input logic b,
                                           input logic [10:0] div);
    logic [11:0] t;
    t = {rem, b};
    if (t >= {1'b0, div})
      t = t - {1'b0, div};
    return t[10:0];
  endfunction

  // returns {quotient bit, new remainder}
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic b,
                                           input logic [30:0] div);
    logic [32:0] t;
    logic        q;
    t = {rem, b};
    q = 1'b0;
    if (t >= {2'b00, div}) begin
      t = t - {2'b00, div};
      q = 1'b1;
    end
    return {q, t[31:0]};
  endfunction

  // stage 1: range check, time differences, flash gating
  always_comb begin
    logic signed [32:0] el;
    logic signed [32:0] age;
    logic signed [32:0] dur;
    logic signed [32:0] rem_t;
    logic               fen;
    el  = 33'(signed'(in_data.now_time)) - 33'(signed'(in_data.state_start_time));
    age = 33'(signed'(in_data.now_time)) - 33'(signed'(in_data.flash_start_time));
    dur = 33'(signed'(in_data.flash_duration));
    rem_t = dur - age;
    fen = (in_data.flash_revision > 0) &&
          (in_data.flash_duration > 32'sd6) &&
          (in_data.flash_peak > 0) && !age[32] && (age < dur);
    s1_nxt.vld     = in_valid;
    s1_nxt.ok      = ({3'b000, count_eff} > in_data.clip_state);
    s1_nxt.clip    = in_data.clip_state[3:0];
    s1_nxt.loop    = s1_nxt.ok && (in_data.clip_state < 8'(MAX_CLIPS)) &&
                     loop_mask_r[in_data.clip_state[3:0]];
    s1_nxt.elapsed = (el > 0) ? el[31:0] : 32'd0;
    s1_nxt.urate   = (in_data.play_rate > 0) ? in_data.play_rate[14:0] : 15'd0;
    s1_nxt.seed    = in_data.phase_seed;
    s1_nxt.fdiff   = fen ? rem_t[30:0] : 31'd0;
    s1_nxt.fdur    = fen ? in_data.flash_duration[30:0] : 31'd1;
    s1_nxt.peak    = fen ? in_data.flash_peak[14:0] : 15'd0;
  end

  // stage 2: first products
  always_comb begin
    s2_nxt.vld   = s1_r.vld;
    s2_nxt.ok    = s1_r.ok;
    s2_nxt.loop  = s1_r.loop;
    s2_nxt.clip  = s1_r.clip;
    s2_nxt.prod  = 40'(s1_r.elapsed) * 40'(sample_rate_r);
    s2_nxt.urate = s1_r.urate;
    s2_nxt.seed  = s1_r.seed;
    s2_nxt.fnum  = 46'(s1_r.fdiff) * 46'(s1_r.peak);
    s2_nxt.fdur  = s1_r.fdur;
  end

  // stage 3: local position in Q.8 frames, divider set-up
  always_comb begin
    logic [54:0] p;
    p = 55'(s2_r.prod) * 55'(s2_r.urate);
    dv_nxt[0].vld       = s2_r.vld;
    dv_nxt[0].ok        = s2_r.ok;
    dv_nxt[0].loop      = s2_r.loop;
    dv_nxt[0].clip      = s2_r.clip;
    dv_nxt[0].local_pos = p[54:16];
    dv_nxt[0].seed      = s2_r.seed;
    dv_nxt[0].srem      = '0;
    dv_nxt[0].lrem      = '0;
    dv_nxt[0].fnum      = s2_r.fnum;
    dv_nxt[0].fdur      = s2_r.fdur;
    dv_nxt[0].frem      = {2'b00, s2_r.fnum[45:16]};
    dv_nxt[0].fq        = '0;
  end

  // divider stages
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    always_comb begin
      logic [31:0] lint;
      logic [32:0] st;
      dv_nxt[i+1] = dv_r[i];
      lint = {1'b0, dv_r[i].local_pos[38:8]};
      for (int j = 0; j < MOD_STEPS; j++) begin
        dv_nxt[i+1].srem = mod_step(dv_nxt[i+1].srem,
                                    dv_r[i].seed[31 - MOD_STEPS*i - j], frames_eff);
        dv_nxt[i+1].lrem = mod_step(dv_nxt[i+1].lrem,
                                    lint[31 - MOD_STEPS*i - j], frames_eff);
      end
      for (int j = 0; j < FQ_STEPS; j++) begin
        st = div_step(dv_nxt[i+1].frem, dv_r[i].fnum[15 - FQ_STEPS*i - j],
                      dv_r[i].fdur);
        dv_nxt[i+1].frem = st[31:0];
        dv_nxt[i+1].fq[15 - FQ_STEPS*i - j] = st[32];
      end
    end
  end

  // output stage: wrap or clamp, previous frame
  always_comb begin
    dv_t         d;
    logic [11:0] rsum;
    logic [10:0] r;
    logic [10:0] rp;
    logic [14:0] start;
    logic [23:0] start_q;
    logic [18:0] last;
    logic [18:0] lc;
    logic [23:0] pos;
    logic [23:0] prior;
    d     = dv_r[DIV_STAGES];
    rsum  = {1'b0, d.srem} + {1'b0, d.lrem};
    if (rsum >= {1'b0, frames_eff})
      rsum = rsum - {1'b0, frames_eff};
    r       = rsum[10:0];
    rp      = (r == 11'd0) ? (frames_eff - 11'd1) : (r - 11'd1);
    start   = 15'(d.clip) * 15'(frames_eff);
    start_q = {1'b0, start, 8'h00};
    last    = {frames_eff - 11'd1, 8'h00};
    lc      = (d.local_pos > 39'(last)) ? last : d.local_pos[18:0];
    if (d.loop) begin
      pos   = start_q + 24'({r, d.local_pos[7:0]});
      prior = start_q + 24'({rp, d.local_pos[7:0]});
    end else begin
      pos   = start_q + 24'(lc);
      prior = (lc >= 19'd256) ? (pos - 24'd256) : start_q;
    end
    out_nxt = '0;
    if (d.ok) begin
      out_nxt.result_valid    = 1'b1;
      out_nxt.clip_index      = d.clip;
      out_nxt.is_looping      = d.loop;
      out_nxt.frame_pos       = pos[21:0];
      out_nxt.prior_frame_pos = prior[21:0];
      out_nxt.flash_level     = d.fq[14:0];
    end
  end

  // only the valid bits are reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld    <= 1'b0;
      s2_r.vld    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= DIV_STAGES; k++)
        dv_r[k].vld <= 1'b0;
    end else if (en) begin
      s1_r        <= s1_nxt;
      s2_r        <= s2_nxt;
      out_valid_r <= dv_r[DIV_STAGES].vld;
      out_r       <= out_nxt;
      for (int k = 0; k <= DIV_STAGES; k++)
        dv_r[k] <= dv_nxt[k];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `CFPS_ASSERT(a_reset_empty, $past(!rst_n) |-> !out_valid, "output valid just after reset")
  `CFPS_ASSERT(a_invalid_zero, out_valid && !out_data.result_valid |-> out_data.frame_pos == 22'd0 && out_data.flash_level == 15'd0, "rejected clip with non-zero result")
  `CFPS_ASSERT(a_loop_valid, out_valid && out_data.is_looping |-> out_data.result_valid, "looping flag on a rejected clip")
  `CFPS_ASSERT(a_clamp_order, out_valid && out_data.result_valid && !out_data.is_looping |-> out_data.prior_frame_pos <= out_data.frame_pos, "clamped clip went backwards")

endmodule
